### rtl/mbd_pkg.sv
// Shared types, constants and codes of the multi-button debouncer.
package mbd_pkg;

    localparam int NUM_BUTTONS_DEF = 6;

    localparam int ACT_W       = 3;
    localparam int PIN_W       = 6;
    localparam int TIME_W      = 32;
    localparam int BTN_W       = 3;
    localparam int MASK_W      = 6;
    localparam int CMAX_W      = 8;
    localparam int LOCK_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CMAX_W-1:0] CMAX_RST = 8'd20;
    localparam logic [LOCK_W-1:0] LOCK_RST = 16'd50;

    typedef enum logic [ACT_W-1:0] {
        ACT_SAMPLE     = 3'd0,
        ACT_READ_DOWN  = 3'd1,
        ACT_TAKE_PRESS = 3'd2,
        ACT_TAKE_REL   = 3'd3,
        ACT_CLEAR      = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNTER_MAX = 1'b0,
        CFG_LOCK_MS     = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [TIME_W-1:0] last_ms;
        logic [CMAX_W-1:0] integ;
    } t_entry;

endpackage

### rtl/mbd_entry_mem.sv
// Per-button entry memory with registered read, reset valid bits and write forwarding.
module mbd_entry_mem #(
    parameter int NUM_ENT = mbd_pkg::NUM_BUTTONS_DEF,
    localparam int IDX_W = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [IDX_W-1:0]    i_rd_addr,
    output mbd_pkg::t_entry     o_rd_data,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  mbd_pkg::t_entry     i_wr_data
);

    mbd_pkg::t_entry r_mem [NUM_ENT];
    logic [NUM_ENT-1:0] r_vld;
    mbd_pkg::t_entry r_rd_data;
    mbd_pkg::t_entry r_fwd_data;
    logic r_rd_vld;
    logic r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld  <= r_vld[i_rd_addr];
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // An entry never written reads as its reset value of zero.
    assign o_rd_data = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);

endmodule

### rtl/multi_button_debouncer_core.sv
// Top level of the multi-button debouncer with integrating counters and lockout.
//
// A sample word walks the buttons through one shared entry memory, one button per
// cycle while the output does not stall, so it holds the input side until its last
// button is issued; a read, take or clear word is issued at once. Each word passes the
// input register, the stage-1 register and the output register; a sample word gives
// its result word after its last button, when the output is free. The next word is
// accepted while the previous one is still in the memory pipeline; a result word
// waiting in the output register stalls the whole pipeline and the input until taken.
module multi_button_debouncer_core #(
    parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // Fields from bit 0: pin_levels[5:0], now_ms[37:6], button[40:38], zeros.
    input  logic [mbd_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // Fields from bit 0: action[2:0].
    input  logic [mbd_pkg::ACT_W-1:0]           i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // Fields from bit 0: answer[0], down_mask[6:1], zero.
    output logic [mbd_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    logic [mbd_pkg::CMAX_W-1:0] r_cmax;
    logic [mbd_pkg::LOCK_W-1:0] r_lock;

    logic                        r_busy;
    logic [mbd_pkg::ACT_W-1:0]   r_act;
    logic [mbd_pkg::PIN_W-1:0]   r_pins;
    logic [mbd_pkg::TIME_W-1:0]  r_now;
    logic [mbd_pkg::BTN_W-1:0]   r_btn;
    logic [IDX_W-1:0]            r_idx;

    logic                        r_s1_valid;
    logic [mbd_pkg::ACT_W-1:0]   r_s1_act;
    logic [mbd_pkg::TIME_W-1:0]  r_s1_now;
    logic [mbd_pkg::BTN_W-1:0]   r_s1_btn;
    logic [IDX_W-1:0]            r_s1_idx;
    logic                        r_s1_low;
    logic                        r_s1_last;

    logic [NUM_BUTTONS-1:0] r_down, r_press, r_rel;
    logic [NUM_BUTTONS-1:0] n_down, n_press, n_rel;

    logic                        r_out_valid;
    logic [mbd_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic en, issue, is_samp, issue_last, s_acc;
    logic [NUM_BUTTONS-1:0] w_pin_ext;
    logic [mbd_pkg::MASK_W-1:0] w_mask;
    mbd_pkg::t_entry rd_ent, wr_ent;
    logic locked, s1_samp, btn_ok, answer;
    logic [IDX_W-1:0] bidx;
    logic [mbd_pkg::TIME_W-1:0] elapsed;

    assign en         = !r_out_valid || i_m_tready;
    assign is_samp    = (r_act == mbd_pkg::ACT_SAMPLE);
    assign issue      = r_busy && en;
    assign issue_last = !is_samp || (r_idx == LAST_IDX);
    assign o_s_tready = en && (!r_busy || issue_last);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Buttons beyond the pin field read their pin as low.
    for (genvar j = 0; j < NUM_BUTTONS; j++) begin : g_pin
        if (j < mbd_pkg::PIN_W) begin : g_in
            assign w_pin_ext[j] = r_pins[j];
        end else begin : g_out
            assign w_pin_ext[j] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmax <= mbd_pkg::CMAX_RST;
            r_lock <= mbd_pkg::LOCK_RST;
        end else if (i_cfg_we) begin
            unique case (mbd_pkg::t_cfg_reg'(i_cfg_idx))
                mbd_pkg::CFG_COUNTER_MAX: r_cmax <= i_cfg_wdata[mbd_pkg::CMAX_W-1:0];
                mbd_pkg::CFG_LOCK_MS:     r_lock <= i_cfg_wdata[mbd_pkg::LOCK_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (s_acc) begin
            r_busy <= 1'b1;
        end else if (issue && issue_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_act  <= i_s_tuser;
            r_pins <= i_s_tdata[5:0];
            r_now  <= i_s_tdata[37:6];
            r_btn  <= i_s_tdata[40:38];
            r_idx  <= '0;
        end else if (issue && !issue_last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_act  <= r_act;
            r_s1_now  <= r_now;
            r_s1_btn  <= r_btn;
            r_s1_idx  <= r_idx;
            r_s1_low  <= !w_pin_ext[r_idx];
            r_s1_last <= issue_last;
        end
    end

    assign s1_samp = r_s1_valid && (r_s1_act == mbd_pkg::ACT_SAMPLE);

    mbd_entry_mem #(
        .NUM_ENT  (NUM_BUTTONS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (issue && is_samp),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_ent),
        .i_wr_en   (en && s1_samp),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (wr_ent)
    );

    assign elapsed = r_s1_now - rd_ent.last_ms;
    assign locked  = elapsed <= {{(mbd_pkg::TIME_W - mbd_pkg::LOCK_W){1'b0}}, r_lock};
    assign btn_ok  = 32'(r_s1_btn) < NUM_BUTTONS;
    assign bidx    = IDX_W'(r_s1_btn);

    always_comb begin
        n_down  = r_down;
        n_press = r_press;
        n_rel   = r_rel;
        wr_ent  = rd_ent;
        answer  = 1'b0;
        if (r_s1_valid) begin
            unique case (r_s1_act)
                mbd_pkg::ACT_SAMPLE: begin
                    if (r_s1_low) begin
                        if (rd_ent.integ < r_cmax) begin
                            wr_ent.integ = rd_ent.integ + 1'b1;
                        end else if (!r_down[r_s1_idx] && !locked) begin
                            n_down[r_s1_idx]  = 1'b1;
                            n_press[r_s1_idx] = 1'b1;
                            wr_ent.last_ms    = r_s1_now;
                        end
                    end else begin
                        if (rd_ent.integ != '0) begin
                            wr_ent.integ = rd_ent.integ - 1'b1;
                        end else if (r_down[r_s1_idx] && !locked) begin
                            n_down[r_s1_idx] = 1'b0;
                            n_rel[r_s1_idx]  = 1'b1;
                            wr_ent.last_ms   = r_s1_now;
                        end
                    end
                end
                mbd_pkg::ACT_READ_DOWN: begin
                    if (btn_ok) begin
                        answer = r_down[bidx];
                    end
                end
                mbd_pkg::ACT_TAKE_PRESS: begin
                    if (btn_ok) begin
                        answer         = r_press[bidx];
                        n_press[bidx]  = 1'b0;
                    end
                end
                mbd_pkg::ACT_TAKE_REL: begin
                    if (btn_ok) begin
                        answer       = r_rel[bidx];
                        n_rel[bidx]  = 1'b0;
                    end
                end
                mbd_pkg::ACT_CLEAR: begin
                    n_press = '0;
                    n_rel   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down  <= '0;
            r_press <= '0;
            r_rel   <= '0;
        end else if (en) begin
            r_down  <= n_down;
            r_press <= n_press;
            r_rel   <= n_rel;
        end
    end

    for (genvar j = 0; j < mbd_pkg::MASK_W; j++) begin : g_mask
        if (j < NUM_BUTTONS) begin : g_in
            assign w_mask[j] = n_down[j];
        end else begin : g_out
            assign w_mask[j] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && r_s1_valid && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid && r_s1_last) begin
            r_out_data <= {1'b0, w_mask, answer};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### rtl/mbd_checker.sv
// Port-level checker of the multi-button debouncer and its bind to the top level.
module mbd_checker #(
    parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [mbd_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    localparam logic [mbd_pkg::MASK_W-1:0] LEGAL_MASK =
        (NUM_BUTTONS >= mbd_pkg::MASK_W) ? '1 : mbd_pkg::MASK_W'((1 << NUM_BUTTONS) - 1);

    logic [2:0] r_cnt;
    logic in_acc, out_acc;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("Result word valid right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled result word changed or dropped.");

    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6:1] & ~LEGAL_MASK) == '0)
        else $error("Down mask shows a button that does not exist.");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_cnt != '0)
        else $error("Result word without an accepted input word.");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd3)
        else $error("More words in flight than the pipeline holds.");

endmodule

bind multi_button_debouncer_core mbd_checker #(
    .NUM_BUTTONS (NUM_BUTTONS)
) u_mbd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### sim/tb_multi_button_debouncer_core.sv
// Self-checking testbench for the multi-button debouncer core with a scoreboard class.
module tb_multi_button_debouncer_core;
    import mbd_pkg::*;

    localparam int NB            = NUM_BUTTONS_DEF;
    localparam int PAD_W         = IN_TDATA_W - (PIN_W + TIME_W + BTN_W);
    localparam int NUM_PHASES    = 8;
    localparam int WORDS_PER_PH  = 103;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RUN_LIMIT     = 1000000;
    localparam int MAX_PRINTS    = 200;

    localparam logic [ACT_W-1:0] ACT_RSVD_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_HI = 3'd7;

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} t_rx_mode;

    typedef struct packed {
        logic              answer;
        logic [MASK_W-1:0] down_mask;
    } debounce_result_t;

    class debounce_scoreboard;
        logic [CMAX_W-1:0] cmax;
        logic [LOCK_W-1:0] lock_win;
        logic [CMAX_W-1:0] integ [NB];
        bit                is_down [NB];
        bit                press_flag [NB];
        bit                rel_flag [NB];
        logic [TIME_W-1:0] last_ms [NB];
        debounce_result_t  expected_q [$];
        int                errors;

        function new();
            cmax     = CMAX_RST;
            lock_win = LOCK_RST;
            errors   = 0;
            for (int i = 0; i < NB; i++) begin
                integ[i]      = '0;
                is_down[i]    = 1'b0;
                press_flag[i] = 1'b0;
                rel_flag[i]   = 1'b0;
                last_ms[i]    = '0;
            end
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_COUNTER_MAX: cmax = val[CMAX_W-1:0];
                CFG_LOCK_MS:     lock_win = val[LOCK_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(logic [ACT_W-1:0] act, logic [PIN_W-1:0] pins,
                                logic [TIME_W-1:0] now, logic [BTN_W-1:0] btn);
            debounce_result_t  res;
            logic [TIME_W-1:0] age;
            bit                locked;
            bit                hit;
            hit = (btn < NB);
            res = '0;
            case (act)
                ACT_SAMPLE: begin
                    for (int i = 0; i < NB; i++) begin
                        age    = now - last_ms[i];
                        locked = (age <= {{(TIME_W-LOCK_W){1'b0}}, lock_win});
                        if (!pins[i]) begin
                            if (integ[i] < cmax) begin
                                integ[i] = integ[i] + 1'b1;
                            end else if (!is_down[i] && !locked) begin
                                is_down[i]    = 1'b1;
                                press_flag[i] = 1'b1;
                                last_ms[i]    = now;
                            end
                        end else begin
                            if (integ[i] != '0) begin
                                integ[i] = integ[i] - 1'b1;
                            end else if (is_down[i] && !locked) begin
                                is_down[i]  = 1'b0;
                                rel_flag[i] = 1'b1;
                                last_ms[i]  = now;
                            end
                        end
                    end
                end
                ACT_READ_DOWN: begin
                    if (hit) res.answer = is_down[btn];
                end
                ACT_TAKE_PRESS: begin
                    if (hit) begin
                        res.answer      = press_flag[btn];
                        press_flag[btn] = 1'b0;
                    end
                end
                ACT_TAKE_REL: begin
                    if (hit) begin
                        res.answer    = rel_flag[btn];
                        rel_flag[btn] = 1'b0;
                    end
                end
                ACT_CLEAR: begin
                    for (int i = 0; i < NB; i++) begin
                        press_flag[i] = 1'b0;
                        rel_flag[i]   = 1'b0;
                    end
                end
                default: ;
            endcase
            for (int i = 0; i < NB; i++) res.down_mask[i] = is_down[i];
            expected_q.push_back(res);
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            if (errors < MAX_PRINTS)
                $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic answer, logic [MASK_W-1:0] mask);
            debounce_result_t want;
            if (expected_q.size() == 0) begin
                report("result word with nothing outstanding", 8'({answer, mask}), 8'd0);
                return;
            end
            want = expected_q.pop_front();
            if (answer !== want.answer) report("answer", 8'(answer), 8'(want.answer));
            if (mask !== want.down_mask) report("down_mask", 8'(mask), 8'(want.down_mask));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [ACT_W-1:0]       i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    debounce_scoreboard sb = new();
    int burst_left = 0;
    bit hold_req   = 1'b0;

    multi_button_debouncer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_rx_mode mode;
        int       left;
        mode       = RX_OPEN;
        left       = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 2));
                left = $urandom_range(10, 120);
            end
            left--;
            case (mode)
                RX_OPEN: i_m_tready <= 1'b1;
                RX_HALF: i_m_tready <= 1'($urandom_range(0, 1));
                default: i_m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata[0], o_m_tdata[MASK_W:1]);
    end

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [PIN_W-1:0] pins,
                             input logic [TIME_W-1:0] now, input logic [BTN_W-1:0] btn);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {{PAD_W{1'b0}}, btn, now, pins};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_word(act, pins, now, btn);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CMAX_W-1:0] cmax, input logic [LOCK_W-1:0] lock_win);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_COUNTER_MAX;
        i_cfg_wdata <= CFG_DATA_W'(cmax);
        @(posedge i_clk);
        sb.write_reg(CFG_COUNTER_MAX, CFG_DATA_W'(cmax));
        i_cfg_idx   <= CFG_LOCK_MS;
        i_cfg_wdata <= lock_win;
        @(posedge i_clk);
        sb.write_reg(CFG_LOCK_MS, lock_win);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int                phase_cmax [NUM_PHASES];
        int                phase_lock [NUM_PHASES];
        int                lock_now;
        int                pick;
        logic [PIN_W-1:0]  held;
        logic [PIN_W-1:0]  pins;
        logic [TIME_W-1:0] now_t;

        phase_cmax = '{5, 12, 2, 0, 7, 1, 255, 4};
        phase_lock = '{20, 0, 300, 1, 65535, 50, 2, 0};

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: samples at time zero and at the wrap of the time counter.
        send_word(ACT_SAMPLE, 6'h3F, 32'h0000_0000, 3'd0);
        send_word(ACT_SAMPLE, 6'h00, 32'hFFFF_FFFF, 3'd0);
        send_word(ACT_READ_DOWN, 6'h00, 32'h0, 3'd0);
        send_word(ACT_TAKE_PRESS, 6'h00, 32'h0, 3'd5);
        send_word(ACT_TAKE_REL, 6'h00, 32'h0, BTN_W'(NB));
        send_word(ACT_READ_DOWN, 6'h00, 32'h0, '1);
        send_word(ACT_CLEAR, 6'h00, 32'h0, 3'd0);
        for (int a = ACT_RSVD_LO; a <= ACT_RSVD_HI; a++)
            send_word(ACT_W'(a), 6'h00, 32'h0, 3'd0);
        drain_results();

        // Zero maximum and zero lockout: integrators sit at the maximum.
        set_config(8'd0, 16'd0);
        send_word(ACT_SAMPLE, 6'h00, 32'd0, 3'd0);
        send_word(ACT_SAMPLE, 6'h00, 32'd1, 3'd0);
        send_word(ACT_TAKE_PRESS, 6'h00, 32'h0, 3'd0);
        send_word(ACT_TAKE_PRESS, 6'h00, 32'h0, 3'd0);
        send_word(ACT_READ_DOWN, 6'h00, 32'h0, 3'd5);
        send_word(ACT_SAMPLE, 6'h3F, 32'd2, 3'd0);
        send_word(ACT_SAMPLE, 6'h3F, 32'd2, 3'd0);
        send_word(ACT_TAKE_REL, 6'h00, 32'h0, 3'd2);
        send_word(ACT_CLEAR, 6'h00, 32'h0, 3'd0);
        send_word(ACT_TAKE_REL, 6'h00, 32'h0, 3'd3);
        drain_results();

        set_config('1, '1);
        send_word(ACT_SAMPLE, 6'h2A, 32'hFFFF_0000, 3'd0);
        send_word(ACT_SAMPLE, 6'h15, 32'hFFFF_FFFF, 3'd0);
        send_word(ACT_READ_DOWN, 6'h00, 32'h0, 3'd1);
        send_word(ACT_TAKE_PRESS, 6'h00, 32'h0, 3'd4);
        drain_results();

        now_t = 32'hFFFF_FF00;
        held  = 6'h3F;
        for (int p = 0; p < NUM_PHASES; p++) begin
            lock_now = (p == NUM_PHASES - 1) ? $urandom_range(0, 65535) : phase_lock[p];
            set_config(CMAX_W'(phase_cmax[p]), LOCK_W'(lock_now));
            for (int n = 0; n < WORDS_PER_PH; n++) begin
                if (p == 0 && n == 10) hold_req = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    if ($urandom_range(0, phase_cmax[p] + 2) == 0) begin
                        if ($urandom_range(0, 1) == 0)
                            held = PIN_W'($urandom);
                        else
                            held[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
                    end
                    pins = held;
                    if ($urandom_range(0, 9) == 0) pins[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        now_t = $urandom;
                    else
                        now_t = now_t + $urandom_range(0, lock_now + 1);
                    send_word(ACT_SAMPLE, pins, now_t, BTN_W'($urandom));
                end else if (pick < 94) begin
                    send_word(ACT_W'($urandom_range(ACT_READ_DOWN, ACT_TAKE_REL)),
                              PIN_W'($urandom), $urandom, BTN_W'($urandom));
                end else if (pick < 97) begin
                    send_word(ACT_CLEAR, PIN_W'($urandom), $urandom, BTN_W'($urandom));
                end else begin
                    send_word(ACT_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI)),
                              PIN_W'($urandom), $urandom, BTN_W'($urandom));
                end
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
